/* sv/rfpf_pkg.sv */
`default_nettype none

package rfpf_pkg;

	typedef logic [1:0]  op_t;
	typedef logic [10:0] coord_t;
	typedef logic [10:0] side_t;

	localparam op_t OP_FLIP  = 2'd0;
	localparam op_t OP_QUERY = 2'd1;
	localparam op_t OP_CLEAR = 2'd2;

	localparam int    MAX_SIDE_DEF  = 1024;
	localparam side_t GRID_SIDE_RST = 11'd1024;

endpackage

`default_nettype wire

/* sv/rfpf_if.sv */
`default_nettype none

interface rfpf_cmd_if;
	logic                 valid;
	logic                 ready;
	rfpf_pkg::op_t        op;
	rfpf_pkg::coord_t     row_lo;
	rfpf_pkg::coord_t     col_lo;
	rfpf_pkg::coord_t     row_hi;
	rfpf_pkg::coord_t     col_hi;

	modport source (output valid, output op, output row_lo, output col_lo,
		output row_hi, output col_hi, input ready);
	modport sink (input valid, input op, input row_lo, input col_lo,
		input row_hi, input col_hi, output ready);
endinterface

interface rfpf_res_if;
	logic valid;
	logic ready;
	logic cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

/* sv/rfpf_ram.sv */
`default_nettype none

module rfpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/rect_flip_point_parity_fenwick.sv */
// Channel  Direction  Transaction carries
// cmd      in         op, row_lo, col_lo, row_hi, col_hi
// res      out        cell_value, one per query
// cfg      in         grid_side, written whenever cfg_we is high
//
// The tree is kept one grid row per memory word, so each Fenwick row step is a
// read, one update per column step on the held row, and a write back.
// A flip updates the tree at each of its four corners in turn, after a setup step per
// corner; a corner outside the grid is skipped, one inside walks the rows on its path.
// A query walks the rows on its prefix path and XORs the column steps of each.
// A clear, and reset, run a pass over all MAX_SIDE rows that zeroes them in turn.
// A result waits in an output register; cmd takes the next transaction meanwhile.
`default_nettype none

module rect_flip_point_parity_fenwick #(
	parameter int MAX_SIDE = rfpf_pkg::MAX_SIDE_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	rfpf_cmd_if.sink             cmd,
	rfpf_res_if.source           res,
	input  wire logic            cfg_we,
	input  wire rfpf_pkg::side_t cfg_wdata
);

	import rfpf_pkg::*;

	localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int CW = (AW + 2 > 12) ? AW + 2 : 12;

	typedef logic [CW-1:0] idx_t;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLR   = 4'd1;
	localparam logic [3:0] ST_CSET  = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_LOAD  = 4'd4;
	localparam logic [3:0] ST_UPD   = 4'd5;
	localparam logic [3:0] ST_WR    = 4'd6;
	localparam logic [3:0] ST_QRD   = 4'd7;
	localparam logic [3:0] ST_QLOAD = 4'd8;
	localparam logic [3:0] ST_QSUM  = 4'd9;
	localparam logic [3:0] ST_QDONE = 4'd10;

	function automatic idx_t low_bit(input idx_t a);
		return a & (~a + idx_t'(1));
	endfunction

	logic [3:0]          st_q;
	logic [AW-1:0]       clr_cnt_q;
	logic [1:0]          corner_q;
	logic                out_valid_q;
	logic                cell_q;
	side_t               grid_side_q;
	coord_t              row_lo_q, col_lo_q, row_hi_q, col_hi_q;
	idx_t                x_q, y_q, cy_q;
	logic [MAX_SIDE-1:0] row_q;
	logic                acc_q;

	idx_t                side;
	idx_t                corner_r, corner_c;
	logic                corner_skip;
	idx_t                q_r, q_c;
	idx_t                x_up, y_up, x_dn, y_dn;
	idx_t                x_m1, y_m1;
	logic [AW-1:0]       xi, yi;
	logic                cmd_fire;

	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr;
	logic [MAX_SIDE-1:0] ram_wdata, ram_rdata;

	always_comb begin
		side = (idx_t'(grid_side_q) > idx_t'(MAX_SIDE)) ? idx_t'(MAX_SIDE)
			: idx_t'(grid_side_q);
		corner_r = corner_q[0] ? idx_t'(row_hi_q) + idx_t'(1) : idx_t'(row_lo_q);
		corner_c = corner_q[1] ? idx_t'(col_hi_q) + idx_t'(1) : idx_t'(col_lo_q);
		corner_skip = (corner_r == '0) || (corner_c == '0) || (corner_r > side)
			|| (corner_c > side);
		q_r = (idx_t'(cmd.row_lo) > side) ? side : idx_t'(cmd.row_lo);
		q_c = (idx_t'(cmd.col_lo) > side) ? side : idx_t'(cmd.col_lo);
		x_up = x_q + low_bit(x_q);
		y_up = y_q + low_bit(y_q);
		x_dn = x_q - low_bit(x_q);
		y_dn = y_q - low_bit(y_q);
		x_m1 = x_q - idx_t'(1);
		y_m1 = y_q - idx_t'(1);
		xi = x_m1[AW-1:0];
		yi = y_m1[AW-1:0];
	end

	assign cmd.ready  = (st_q == ST_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign res.valid  = out_valid_q;
	assign res.cell_value = cell_q;

	assign ram_we    = (st_q == ST_CLR) || (st_q == ST_WR);
	assign ram_waddr = (st_q == ST_CLR) ? clr_cnt_q : xi;
	assign ram_wdata = (st_q == ST_CLR) ? '0 : row_q;
	assign ram_re    = (st_q == ST_RD) || (st_q == ST_QRD);

	rfpf_ram #(
		.WIDTH (MAX_SIDE),
		.DEPTH (MAX_SIDE)
	) u_tree_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (xi),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_cnt_q   <= '0;
			corner_q    <= '0;
			out_valid_q <= 1'b0;
			grid_side_q <= GRID_SIDE_RST;
		end else begin
			if (cfg_we) begin
				grid_side_q <= cfg_wdata;
			end
			if (res.valid && res.ready && (st_q != ST_QDONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						unique case (cmd.op)
							OP_FLIP: begin
								corner_q <= '0;
								st_q     <= ST_CSET;
							end
							OP_QUERY: begin
								st_q <= ((q_r == '0) || (q_c == '0)) ? ST_QDONE : ST_QRD;
							end
							OP_CLEAR: begin
								clr_cnt_q <= '0;
								st_q      <= ST_CLR;
							end
							default: st_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(MAX_SIDE - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_CSET: begin
					if (corner_skip) begin
						corner_q <= corner_q + 2'd1;
						st_q     <= (corner_q == 2'd3) ? ST_IDLE : ST_CSET;
					end else begin
						st_q <= ST_RD;
					end
				end
				ST_RD:   st_q <= ST_LOAD;
				ST_LOAD: st_q <= ST_UPD;
				ST_UPD: begin
					if (y_up > side) begin
						st_q <= ST_WR;
					end
				end
				ST_WR: begin
					if (x_up > side) begin
						corner_q <= corner_q + 2'd1;
						st_q     <= (corner_q == 2'd3) ? ST_IDLE : ST_CSET;
					end else begin
						st_q <= ST_RD;
					end
				end
				ST_QRD:   st_q <= ST_QLOAD;
				ST_QLOAD: st_q <= ST_QSUM;
				ST_QSUM: begin
					if (y_dn == '0) begin
						st_q <= (x_dn == '0) ? ST_QDONE : ST_QRD;
					end
				end
				ST_QDONE: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q) inside
			ST_IDLE: begin
				row_lo_q <= cmd.row_lo;
				col_lo_q <= cmd.col_lo;
				row_hi_q <= cmd.row_hi;
				col_hi_q <= cmd.col_hi;
				x_q      <= q_r;
				cy_q     <= q_c;
				acc_q    <= 1'b0;
			end
			ST_CSET: begin
				x_q  <= corner_r;
				cy_q <= corner_c;
			end
			ST_LOAD, ST_QLOAD: begin
				row_q <= ram_rdata;
				y_q   <= cy_q;
			end
			ST_UPD: begin
				row_q[yi] <= ~row_q[yi];
				y_q       <= y_up;
			end
			ST_WR: begin
				x_q <= x_up;
			end
			ST_QSUM: begin
				acc_q <= acc_q ^ row_q[yi];
				if (y_dn == '0) begin
					x_q <= x_dn;
				end else begin
					y_q <= y_dn;
				end
			end
			ST_QDONE: begin
				if (!out_valid_q || res.ready) begin
					cell_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q) == ST_QDONE)
		else $error("result raised outside query completion");

	a_update_col_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD) |-> (y_q != '0))
		else $error("column index zero during tree update");

	a_query_idx_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_QSUM) |-> (x_q != '0) && (y_q != '0))
		else $error("index zero during prefix walk");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) && (clr_cnt_q == AW'(MAX_SIDE - 1)) |=> (st_q == ST_IDLE))
		else $error("clearing pass did not end at the last row");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rfpf_pkg::*;

	localparam int   MAX_SIDE      = MAX_SIDE_DEF;
	localparam op_t  OP_UNUSED     = 2'd3;
	localparam int   SETTLE_CYCLES = 2000;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	side_t  cfg_wdata;

	rfpf_cmd_if cmd_ch ();
	rfpf_res_if res_ch ();

	rect_flip_point_parity_fenwick uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	bit [MAX_SIDE:1] flip_bits [1:MAX_SIDE];
	side_t           grid_side;
	bit              pending_parity [$];
	int unsigned     error_count;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;

	function automatic int unsigned low_bit(int unsigned a);
		return a & (~a + 1);
	endfunction

	function automatic int unsigned eff_side();
		return (grid_side > MAX_SIDE) ? MAX_SIDE : int'(grid_side);
	endfunction

	function automatic void toggle_corner(int unsigned r, int unsigned c);
		int unsigned s;
		s = eff_side();
		if (r == 0 || c == 0 || r > s || c > s)
			return;
		for (int unsigned x = r; x <= s; x += low_bit(x))
			for (int unsigned y = c; y <= s; y += low_bit(y))
				flip_bits[x][y] ^= 1'b1;
	endfunction

	function automatic bit prefix_parity(int unsigned r, int unsigned c);
		int unsigned s;
		bit acc;
		s = eff_side();
		acc = 1'b0;
		if (r > s)
			r = s;
		if (c > s)
			c = s;
		for (int unsigned x = r; x > 0; x -= low_bit(x))
			for (int unsigned y = c; y > 0; y -= low_bit(y))
				acc ^= flip_bits[x][y];
		return acc;
	endfunction

	function automatic void apply_cmd(op_t op, coord_t r1, coord_t c1, coord_t r2,
		coord_t c2);
		case (op)
			OP_FLIP: begin
				toggle_corner(int'(r1), int'(c1));
				toggle_corner(int'(r2) + 1, int'(c1));
				toggle_corner(int'(r1), int'(c2) + 1);
				toggle_corner(int'(r2) + 1, int'(c2) + 1);
			end
			OP_QUERY: begin
				pending_parity.push_back(prefix_parity(int'(r1), int'(c1)));
			end
			OP_CLEAR: begin
				foreach (flip_bits[i])
					flip_bits[i] = '0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		error_count++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	always @(posedge clk) begin
		bit want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_parity.size() == 0) begin
				report_mismatch($sformatf("cell_value %0b with no query outstanding",
					res_ch.cell_value));
			end else begin
				want = pending_parity.pop_front();
				if (res_ch.cell_value !== want)
					report_mismatch($sformatf("cell_value %0b, expected %0b",
						res_ch.cell_value, want));
			end
		end
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_cmd(op_t op, coord_t r1, coord_t c1, coord_t r2, coord_t c2);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.op     <= op;
		cmd_ch.row_lo <= r1;
		cmd_ch.col_lo <= c1;
		cmd_ch.row_hi <= r2;
		cmd_ch.col_hi <= c2;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		apply_cmd(op, r1, c1, r2, c2);
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_parity.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid_side(side_t value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		grid_side = value;
	endtask

	function automatic coord_t pick_coord(int unsigned s);
		int unsigned k;
		k = $urandom_range(99);
		if (s == 0)
			return (k < 50) ? coord_t'($urandom_range(0, 3)) : coord_t'($urandom_range(0, 2047));
		if (k < 75)
			return coord_t'($urandom_range(1, s));
		if (k < 81)
			return '0;
		if (k < 88)
			return coord_t'(s);
		if (k < 93)
			return coord_t'(s + 1);
		return coord_t'($urandom_range(0, 2047));
	endfunction

	function automatic coord_t pick_hi(coord_t lo, int unsigned s);
		if ($urandom_range(99) < 85 && lo >= 1 && lo <= s)
			return coord_t'($urandom_range(int'(lo), s));
		return pick_coord(s);
	endfunction

	task automatic test_reset_state();
		send_cmd(OP_QUERY, 11'd1, 11'd1, 11'd0, 11'd0);
		send_cmd(OP_QUERY, 11'd1024, 11'd1024, 11'd2047, 11'd2047);
	endtask

	task automatic test_full_grid_flip();
		send_cmd(OP_FLIP, 11'd1, 11'd1, 11'd1024, 11'd1024);
		send_cmd(OP_QUERY, 11'd1024, 11'd1024, 11'd0, 11'd0);
		send_cmd(OP_QUERY, 11'd2047, 11'd2047, 11'd0, 11'd0);
		send_cmd(OP_QUERY, 11'd1, 11'd1, 11'd1024, 11'd1024);
	endtask

	task automatic test_odd_items();
		send_cmd(OP_FLIP, 11'd0, 11'd5, 11'd3, 11'd9);
		send_cmd(OP_QUERY, 11'd0, 11'd7, 11'd0, 11'd0);
		send_cmd(OP_QUERY, 11'd2, 11'd0, 11'd0, 11'd0);
		send_cmd(OP_FLIP, 11'd9, 11'd9, 11'd3, 11'd4);
		send_cmd(OP_QUERY, 11'd5, 11'd5, 11'd0, 11'd0);
		send_cmd(OP_UNUSED, 11'd2047, 11'd2047, 11'd2047, 11'd2047);
		send_cmd(OP_CLEAR, 11'd1, 11'd1, 11'd1, 11'd1);
		send_cmd(OP_QUERY, 11'd1, 11'd1, 11'd0, 11'd0);
	endtask

	task automatic test_side_limits();
		set_grid_side(11'd0);
		send_cmd(OP_FLIP, 11'd1, 11'd1, 11'd1, 11'd1);
		send_cmd(OP_QUERY, 11'd1, 11'd1, 11'd0, 11'd0);
		set_grid_side(11'd2047);
		send_cmd(OP_FLIP, 11'd1, 11'd1, 11'd2047, 11'd2047);
		send_cmd(OP_QUERY, 11'd1024, 11'd1024, 11'd0, 11'd0);
		set_grid_side(11'd1);
		send_cmd(OP_FLIP, 11'd1, 11'd1, 11'd1, 11'd1);
		send_cmd(OP_QUERY, 11'd1, 11'd1, 11'd0, 11'd0);
		send_cmd(OP_QUERY, 11'd2, 11'd2, 11'd0, 11'd0);
	endtask

	task automatic test_random_batch(side_t side_val, int unsigned n_items);
		int unsigned done_cnt;
		int unsigned s;
		int unsigned k;
		coord_t r1, c1, r2, c2;
		op_t op;
		set_grid_side(side_val);
		s = eff_side();
		done_cnt = 0;
		while (done_cnt < n_items) begin
			k  = $urandom_range(99);
			r1 = pick_coord(s);
			c1 = pick_coord(s);
			r2 = pick_hi(r1, s);
			c2 = pick_hi(c1, s);
			if (k < 50)
				op = OP_FLIP;
			else if (k < 94)
				op = OP_QUERY;
			else if (k < 97)
				op = OP_CLEAR;
			else
				op = OP_UNUSED;
			send_cmd(op, r1, c1, r2, c2);
			if (op != OP_UNUSED)
				done_cnt++;
		end
	endtask

	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.op     = OP_FLIP;
		cmd_ch.row_lo = '0;
		cmd_ch.col_lo = '0;
		cmd_ch.row_hi = '0;
		cmd_ch.col_hi = '0;
		res_ch.ready  = 1'b0;
		grid_side     = GRID_SIDE_RST;
		error_count   = 0;
		send_idle_pct = 34;
		recv_idle_pct = 52;
		foreach (flip_bits[i])
			flip_bits[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_full_grid_flip();
		test_odd_items();
		test_side_limits();
		test_random_batch(11'd16, 60);
		test_random_batch(11'd1000, 50);

		send_idle_pct = 52;
		recv_idle_pct = 34;
		test_random_batch(11'd1, 30);
		test_random_batch(11'd7, 60);
		test_random_batch(11'd2047, 40);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_batch(11'd100, 60);
		test_random_batch(11'd2, 30);
		test_random_batch(11'd1024, 70);

		wait_idle();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
sv/rfpf_pkg.sv
sv/rfpf_if.sv
sv/rfpf_ram.sv
sv/rect_flip_point_parity_fenwick.sv
bench/testbench.sv
